/* rtl/meu_pkg.sv */
// Package for the modular exponentiation unit: widths, codes and state type.
`default_nettype none
package meu_pkg;

  localparam int MOD_W  = 32;
  localparam int EXP_W  = 63;
  localparam int BASE_W = 63;
  localparam int RES_W  = 32;
  localparam int CFG_W  = 32;
  localparam int PROD_W = 2 * MOD_W;
  localparam int DIV_W  = (BASE_W > PROD_W) ? BASE_W : PROD_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int E_W    = (EXP_W > MOD_W) ? EXP_W : MOD_W;

  localparam logic [CFG_W-1:0] MODULUS_RESET = CFG_W'(1000000007);

  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } op_t;

  typedef enum logic {
    TGT_SQ  = 1'b0,
    TGT_ACC = 1'b1
  } tgt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP
  } state_t;

endpackage
`default_nettype wire

/* rtl/modular_exponentiation_unit.sv */
// Modular exponentiation unit: right-to-left square-and-multiply modulo a register.
//
// Usage: pulse start with opcode, base and exponent while busy is low; the
// item is taken at that edge and busy stays high until the result is out.
// The result appears on power_result for exactly one cycle with done high;
// the receiver cannot stall it. Opcode 1 uses modulus minus two as exponent.
// The modulus is written through cfg_valid/cfg_data (cfg_ready is always
// high) and should be changed only while the unit is idle.
// Sequence: a modulus below two gives done in the cycle after start, and busy
// stays low. Otherwise the base is reduced first, then each exponent bit costs
// a multiply step plus a DIV_W-bit reduction for the square (skipped after the
// top set bit) and the same again for a set bit; a final step finishes. A zero
// exponent finishes right after the base reduction.
// The cost is set by the single bit-serial remainder unit (one quotient bit
// per cycle), shared by the base reduction and every product.
// One item is in flight at a time. Reset (rst, synchronous) returns to idle,
// drops done and loads the modulus with 1000000007.
`default_nettype none
module modular_exponentiation_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      opcode,
  input  wire logic [meu_pkg::BASE_W-1:0] base,
  input  wire logic [62:0]               exponent,
  output logic [meu_pkg::RES_W-1:0]      power_result,
  output logic                           done,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [meu_pkg::CFG_W-1:0] cfg_data
);

  meu_pkg::state_t              state, state_next;
  meu_pkg::tgt_t                tgt, tgt_next;
  logic [meu_pkg::MOD_W-1:0]    modulus;
  logic [meu_pkg::MOD_W-1:0]    acc, acc_next;
  logic [meu_pkg::MOD_W-1:0]    sq, sq_next;
  logic [meu_pkg::MOD_W-1:0]    rem, rem_next;
  logic [meu_pkg::DIV_W-1:0]    dividend, dividend_next;
  logic [meu_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [meu_pkg::E_W-1:0]      e, e_next;
  logic                         mflag, mflag_next;
  logic [meu_pkg::RES_W-1:0]    power_result_next;
  logic                         done_next;

  logic [meu_pkg::MOD_W:0]      r_shift;
  logic [meu_pkg::MOD_W:0]      m_ext;
  logic [meu_pkg::MOD_W-1:0]    r_red;
  logic [meu_pkg::MOD_W-1:0]    mul_a;
  logic [meu_pkg::PROD_W-1:0]   prod;
  logic                         mul_acc;

  assign busy      = (state != meu_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // shared remainder step: one dividend bit per cycle
  assign r_shift = {rem, dividend[meu_pkg::DIV_W-1]};
  assign m_ext   = {1'b0, modulus};
  always_comb begin
    if (r_shift >= m_ext) begin
      r_red = meu_pkg::MOD_W'(r_shift - m_ext);
    end else begin
      r_red = r_shift[meu_pkg::MOD_W-1:0];
    end
  end

  // shared multiplier: acc*sq for a set bit, else sq*sq
  assign mul_acc = e[0] && !mflag;
  assign mul_a   = mul_acc ? acc : sq;
  assign prod    = meu_pkg::PROD_W'(mul_a) * meu_pkg::PROD_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= meu_pkg::ST_IDLE;
      done    <= 1'b0;
      modulus <= meu_pkg::MOD_W'(meu_pkg::MODULUS_RESET);
      cnt     <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      cnt   <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data[meu_pkg::MOD_W-1:0];
      end
    end
    tgt          <= tgt_next;
    acc          <= acc_next;
    sq           <= sq_next;
    rem          <= rem_next;
    dividend     <= dividend_next;
    e            <= e_next;
    mflag        <= mflag_next;
    power_result <= power_result_next;
  end

  always_comb begin
    state_next        = state;
    tgt_next          = tgt;
    acc_next          = acc;
    sq_next           = sq;
    rem_next          = rem;
    dividend_next     = dividend;
    cnt_next          = cnt;
    e_next            = e;
    mflag_next        = mflag;
    power_result_next = power_result;
    done_next         = 1'b0;
    unique case (state)
      meu_pkg::ST_IDLE: begin
        if (start) begin
          if (modulus < meu_pkg::MOD_W'(2)) begin
            power_result_next = '0;
            done_next         = 1'b1;
          end else begin
            acc_next      = meu_pkg::MOD_W'(1);
            mflag_next    = 1'b0;
            tgt_next      = meu_pkg::TGT_SQ;
            rem_next      = '0;
            dividend_next = meu_pkg::DIV_W'(base);
            cnt_next      = meu_pkg::CNT_W'(meu_pkg::DIV_W);
            if (meu_pkg::op_t'(opcode) == meu_pkg::OP_INVERSE) begin
              e_next = meu_pkg::E_W'(modulus - meu_pkg::MOD_W'(2));
            end else begin
              e_next = meu_pkg::E_W'(exponent[meu_pkg::EXP_W-1:0]);
            end
            state_next = meu_pkg::ST_REDUCE;
          end
        end
      end
      meu_pkg::ST_REDUCE: begin
        rem_next      = r_red;
        dividend_next = dividend << 1;
        cnt_next      = cnt - meu_pkg::CNT_W'(1);
        if (cnt == meu_pkg::CNT_W'(1)) begin
          if (tgt == meu_pkg::TGT_ACC) begin
            acc_next = r_red;
          end else begin
            sq_next = r_red;
          end
          state_next = meu_pkg::ST_STEP;
        end
      end
      meu_pkg::ST_STEP: begin
        rem_next      = '0;
        dividend_next = meu_pkg::DIV_W'(prod);
        cnt_next      = meu_pkg::CNT_W'(meu_pkg::DIV_W);
        priority if (e == '0 || (!mul_acc && (e >> 1) == '0)) begin
          power_result_next = meu_pkg::RES_W'(acc);
          done_next         = 1'b1;
          cnt_next          = '0;
          state_next        = meu_pkg::ST_IDLE;
        end else if (mul_acc) begin
          tgt_next   = meu_pkg::TGT_ACC;
          mflag_next = 1'b1;
          state_next = meu_pkg::ST_REDUCE;
        end else begin
          tgt_next   = meu_pkg::TGT_SQ;
          mflag_next = 1'b0;
          e_next     = e >> 1;
          state_next = meu_pkg::ST_REDUCE;
        end
      end
      default: begin
        state_next = meu_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor finished");
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without an item");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");
  a_reduce_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == meu_pkg::ST_REDUCE) |-> (cnt != '0 && cnt <= meu_pkg::CNT_W'(meu_pkg::DIV_W)))
    else $error("remainder counter out of range");
`endif

endmodule
`default_nettype wire
